### hdl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer task queue package
// Shared types and codes for the timer task queue and its arithmetic unit.
// ----------------------------------------------------------------------------
package ptq_pkg;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_SEND     = 3'd1;
   localparam logic [2:0] FUNC_DELAY    = 3'd2;
   localparam logic [2:0] FUNC_PERIODIC = 3'd3;
   localparam logic [2:0] FUNC_CANCEL   = 3'd4;

   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_ID   = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  delay_seconds;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [7:0]  payload_handle;
      logic [15:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] out_ip;
      logic [15:0] out_port;
      logic [7:0]  out_handle;
      logic [15:0] out_id;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        due;
      logic        earlier;
      logic        id_match;
   } ptq_alu_type;

endpackage

### hdl/periodic_timer_task_queue_top.sv
// ----------------------------------------------------------------------------
// Periodic timer task queue
// Table of timed send tasks served in earliest-deadline order.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_data) takes one command per
// transfer: tick, send now, schedule a one-shot, schedule a periodic task or
// cancel by id. The response channel (rsp_valid, rsp_stall, rsp_data) returns
// send, id and drop events; the final event of a command has last set.
// The block takes one command at a time and stalls the request channel while
// it works. Scheduling walks the valid bits, one slot per cycle, to find a
// free slot. Cancel reads every slot once through the single read port of
// the slot memory. A tick makes one pass over the slot memory. Each due task
// is then sent, and every due task but the last is followed by a further
// pass.
// Reset clears the clock, all valid bits and the output valid flag and sets
// the id counter to one. A held response does not block a new command, but
// the next event waits until the held one completes its transfer.
// ----------------------------------------------------------------------------
module periodic_timer_task_queue_top import ptq_pkg::*; #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ID_EXT = (ID_BITS > 16) ? ID_BITS : 16;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef struct packed {
      logic [31:0]        deadline;
      logic [7:0]         interval;
      logic [ID_BITS-1:0] task_id;
      logic [31:0]        ip;
      logic [15:0]        port;
      logic [7:0]         handle;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE_SCAN,
      ST_TICK_SCAN,
      ST_TICK_SEND,
      ST_CANCEL_SCAN,
      ST_EMIT
   } state_type;

   function automatic logic [15:0] id_to_out(input logic [ID_BITS-1:0] id);
      logic [ID_EXT-1:0] e;
      e = ID_EXT'(id);
      return e[15:0];
   endfunction

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [31:0]        now_ff, now_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic [ID_BITS-1:0] id_inc;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [SLOTS-1:0]   pending_ff, pending_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic               issue_on_ff, issue_on_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               first_ff, first_in;
   logic               best_found_ff, best_found_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   slot_type           best_ff, best_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        id_ff, id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   slot_type           slot_mem [SLOTS];
   slot_type           rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   slot_type           mem_wd;

   logic               out_free;
   logic               scan_cand;
   logic [7:0]         alu_addend;
   ptq_alu_type        alu_res;

   assign alu_addend = (state_ff == ST_FREE_SCAN) ? req_ff.delay_seconds : best_ff.interval;

   ptq_alu #(
      .ID_BITS(ID_BITS)
   ) u_alu (
      .now_seconds  (now_ff),
      .addend       (alu_addend),
      .deadline     (rd_data_ff.deadline),
      .best_deadline(best_ff.deadline),
      .task_id      (rd_data_ff.task_id),
      .cancel_id    (req_ff.cancel_id),
      .result       (alu_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_cand = first_ff ? (valid_ff[rd_idx_ff] & alu_res.due) : pending_ff[rd_idx_ff];
   assign id_inc    = next_id_ff + 1'b1;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      now_in        = now_ff;
      next_id_in    = next_id_ff;
      valid_in      = valid_ff;
      pending_in    = pending_ff;
      cnt_in        = cnt_ff;
      issue_idx_in  = issue_idx_ff;
      issue_on_in   = issue_on_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      first_in      = first_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wa        = best_idx_ff;
      mem_wd        = best_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (issue_on_ff) begin
         rd_vld_in = 1'b1;
         rd_idx_in = issue_idx_ff;
         if (issue_idx_ff == LAST_IDX) begin
            issue_on_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               issue_idx_in = '0;
               case (req_data.func)
                  FUNC_TICK: begin
                     now_in        = now_ff + 32'd1;
                     first_in      = 1'b1;
                     best_found_in = 1'b0;
                     cnt_in        = '0;
                     issue_on_in   = 1'b1;
                     state_in      = ST_TICK_SCAN;
                  end
                  FUNC_SEND: begin
                     kind_in  = KIND_SEND;
                     id_in    = '0;
                     state_in = ST_EMIT;
                  end
                  FUNC_DELAY, FUNC_PERIODIC: begin
                     state_in = ST_FREE_SCAN;
                  end
                  FUNC_CANCEL: begin
                     issue_on_in = 1'b1;
                     state_in    = ST_CANCEL_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FREE_SCAN: begin
            if (!valid_ff[issue_idx_ff]) begin
               mem_we          = 1'b1;
               mem_wa          = issue_idx_ff;
               mem_wd.deadline = alu_res.sum;
               mem_wd.ip       = req_ff.dest_ip;
               mem_wd.port     = req_ff.dest_port;
               mem_wd.handle   = req_ff.payload_handle;
               valid_in[issue_idx_ff] = 1'b1;
               if (req_ff.func == FUNC_PERIODIC) begin
                  mem_wd.interval = req_ff.delay_seconds;
                  mem_wd.task_id  = next_id_ff;
                  kind_in         = KIND_ID;
                  id_in           = id_to_out(next_id_ff);
                  next_id_in      = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                  state_in        = ST_EMIT;
               end else begin
                  mem_wd.interval = '0;
                  mem_wd.task_id  = '0;
                  state_in        = ST_IDLE;
               end
            end else if (issue_idx_ff == LAST_IDX) begin
               kind_in  = KIND_DROP;
               id_in    = '0;
               state_in = ST_EMIT;
            end else begin
               issue_idx_in = issue_idx_ff + 1'b1;
            end
         end
         ST_TICK_SCAN: begin
            if (rd_vld_ff) begin
               if (first_ff) begin
                  pending_in[rd_idx_ff] = scan_cand;
                  cnt_in = cnt_ff + CNT_W'(scan_cand);
               end
               if (scan_cand && (!best_found_ff || alu_res.earlier)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_in       = rd_data_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = best_found_in ? ST_TICK_SEND : ST_IDLE;
               end
            end
         end
         ST_TICK_SEND: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.event_kind = KIND_SEND;
               rsp_in.out_ip     = best_ff.ip;
               rsp_in.out_port   = best_ff.port;
               rsp_in.out_handle = best_ff.handle;
               rsp_in.out_id     = id_to_out(best_ff.task_id);
               rsp_in.last       = (cnt_ff == CNT_W'(1));
               if (best_ff.interval != '0) begin
                  mem_we          = 1'b1;
                  mem_wd.deadline = alu_res.sum;
               end else begin
                  valid_in[best_idx_ff] = 1'b0;
               end
               pending_in[best_idx_ff] = 1'b0;
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  first_in      = 1'b0;
                  best_found_in = 1'b0;
                  issue_on_in   = 1'b1;
                  issue_idx_in  = '0;
                  state_in      = ST_TICK_SCAN;
               end
            end
         end
         ST_CANCEL_SCAN: begin
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff] && alu_res.id_match) begin
                  valid_in[rd_idx_ff] = 1'b0;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.event_kind = kind_ff;
               rsp_in.out_ip     = req_ff.dest_ip;
               rsp_in.out_port   = req_ff.dest_port;
               rsp_in.out_handle = req_ff.payload_handle;
               rsp_in.out_id     = id_ff;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         next_id_ff    <= ID_BITS'(1);
         valid_ff      <= '0;
         pending_ff    <= '0;
         cnt_ff        <= '0;
         issue_idx_ff  <= '0;
         issue_on_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_idx_ff     <= '0;
         first_ff      <= 1'b0;
         best_found_ff <= 1'b0;
         best_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         next_id_ff    <= next_id_in;
         valid_ff      <= valid_in;
         pending_ff    <= pending_in;
         cnt_ff        <= cnt_in;
         issue_idx_ff  <= issue_idx_in;
         issue_on_ff   <= issue_on_in;
         rd_vld_ff     <= rd_vld_in;
         rd_idx_ff     <= rd_idx_in;
         first_ff      <= first_in;
         best_found_ff <= best_found_in;
         best_idx_ff   <= best_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      best_ff <= best_in;
      kind_ff <= kind_in;
      id_ff   <= id_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[issue_idx_ff];
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOTS))
      else $error("due task count exceeds the slot count");

   a_pending_valid: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~valid_ff) == '0)
      else $error("a due task is marked in a free slot");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pending_ff == '0 && cnt_ff == '0))
      else $error("due tasks remain after a tick ended");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_SEND && out_free) |=> (rsp_ff.last == (state_ff == ST_IDLE)))
      else $error("last flag does not match the end of a tick");
`endif

endmodule

### hdl/ptq_alu.sv
// ----------------------------------------------------------------------------
// Timer queue arithmetic unit
// Shared deadline adder and the due, ordering and id compares for one slot.
// ----------------------------------------------------------------------------
module ptq_alu import ptq_pkg::*; #(
   parameter int ID_BITS = 16
) (
   input  logic [31:0]        now_seconds,
   input  logic [7:0]         addend,
   input  logic [31:0]        deadline,
   input  logic [31:0]        best_deadline,
   input  logic [ID_BITS-1:0] task_id,
   input  logic [15:0]        cancel_id,
   output ptq_alu_type        result
);

   localparam int ID_EXT = (ID_BITS > 16) ? ID_BITS : 16;

   logic [ID_EXT-1:0] id_ext;
   logic [ID_EXT-1:0] cid_ext;

   assign id_ext  = ID_EXT'(task_id);
   assign cid_ext = ID_EXT'(cancel_id);

   always_comb begin
      result.sum      = now_seconds + 32'(addend);
      result.due      = (deadline <= now_seconds);
      result.earlier  = (deadline < best_deadline);
      result.id_match = (id_ext == cid_ext);
   end

endmodule
